FILE: sv/tscq_pkg.sv
// Shared types and codes for the timed state change queue.
`timescale 1ns / 1ps

package tscq_pkg;

    localparam int TIME_W  = 32;
    localparam int STATE_W = 16;
    localparam int COUNT_OUT_W = 5;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_INITIAL_STATE = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0]  due;
        logic [STATE_W-1:0] state;
    } entry_t;

endpackage

FILE: sv/timed_state_change_queue_core.sv
// Top level of the timed state change queue: sorted timer queue in one memory.
`timescale 1ns / 1ps

// Timed state change queue.
// Input channel (s_valid/s_ready): one item is either a schedule (s_command
// low) that enters s_next_state due at s_now_ms + s_delay_ms, or a tick
// (s_command high) that pops the head entry when its due time is at or
// before s_now_ms. Every item gives exactly one result on the m_ channel:
// the current state, the fired and dropped flags and the pending count.
// The queue lives in a circular buffer memory (QUEUE_DEPTH entries, one read
// port with registered data, one write port), kept sorted by due time.
// A tick goes from accept through S_TICK and S_DONE to the result. A schedule walks back from the
// tail one entry per cycle, moving larger entries up, then places the new entry;
// a full queue drops the item without a walk.
// One item is in work at a time; s_ready is high while the sequencer idles,
// also while an earlier result waits in the output register.
// When the receiver stalls, the finished result holds in the sequencer until
// the output register frees.
// Reset empties the queue and sets the current state and initial_state to 0.
// Writing initial_state (address 0) also loads it into the current state.
module timed_state_change_queue_core
    import tscq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [TIME_W-1:0]      s_now_ms,
    input  logic [STATE_W-1:0]     s_next_state,
    input  logic [TIME_W-1:0]      s_delay_ms,
    input  logic [STATE_W-1:0]     s_override_state,
    // result items
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATE_W-1:0]     m_current_state,
    output logic                   m_fired,
    output logic [COUNT_OUT_W-1:0] m_pending_count,
    output logic                   m_dropped,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_TICK,
        S_DONE
    } state_t;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    // Queue storage: circular buffer, head holds the earliest due time.
    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t state_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] wr_ptr_reg;

    // item held while in work
    logic [TIME_W-1:0]  due_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [STATE_W-1:0] target_reg;
    logic [STATE_W-1:0] override_reg;

    logic [STATE_W-1:0] present_reg;
    logic [STATE_W-1:0] initial_reg;
    logic               fired_reg;
    logic               dropped_reg;

    // output register
    logic                   m_valid_reg;
    logic [STATE_W-1:0]     out_state_reg;
    logic                   out_fired_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_dropped_reg;

    logic s_accept;
    logic cfg_write;
    logic out_free;
    logic move_up;
    logic head_due;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_valid_reg || m_ready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_INITIAL_STATE) ? {16'h0000, initial_reg} : 32'h0;

    // entry read last cycle sits above the new due time: move it up one slot
    assign move_up  = (rd_data_reg.due > due_reg);
    assign head_due = (count_reg != '0) && (rd_data_reg.due <= now_reg);

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    // Read address: head for a tick, tail neighbor for a schedule, then walk back.
    always_comb begin
        if (state_reg == S_SHIFT) begin
            rd_addr = addr_dec(rd_ptr_reg);
        end else if (s_command == CMD_TICK) begin
            rd_addr = head_reg;
        end else begin
            rd_addr = addr_dec(tail_reg);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = wr_ptr_reg;
        wr_data = '{due: due_reg, state: target_reg};
        if (state_reg == S_PLACE) begin
            wr_en = 1'b1;
        end else if (state_reg == S_SHIFT) begin
            wr_en = 1'b1;
            if (move_up) begin
                wr_data = rd_data_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            present_reg     <= '0;
            initial_reg     <= '0;
            m_valid_reg     <= 1'b0;
            fired_reg       <= 1'b0;
            dropped_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_write && (paddr[2] == REG_INITIAL_STATE)) begin
                initial_reg <= pwdata[STATE_W-1:0];
                present_reg <= pwdata[STATE_W-1:0];
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        due_reg      <= s_now_ms + s_delay_ms;
                        now_reg      <= s_now_ms;
                        target_reg   <= s_next_state;
                        override_reg <= s_override_state;
                        fired_reg    <= 1'b0;
                        dropped_reg  <= 1'b0;
                        pos_reg      <= count_reg;
                        wr_ptr_reg   <= tail_reg;
                        rd_ptr_reg   <= addr_dec(tail_reg);
                        if (s_command == CMD_TICK) begin
                            state_reg <= S_TICK;
                        end else if (count_reg == FULL_COUNT) begin
                            dropped_reg <= 1'b1;
                            state_reg   <= S_DONE;
                        end else if (count_reg == '0) begin
                            state_reg <= S_PLACE;
                        end else begin
                            state_reg <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (move_up) begin
                        // entry moved up; continue with the one below it
                        wr_ptr_reg <= rd_ptr_reg;
                        rd_ptr_reg <= addr_dec(rd_ptr_reg);
                        pos_reg    <= pos_reg - 1'b1;
                        if (pos_reg == CW'(1)) begin
                            state_reg <= S_PLACE;
                        end
                    end else begin
                        // new entry written behind it this cycle
                        count_reg <= count_reg + 1'b1;
                        tail_reg  <= addr_inc(tail_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_PLACE: begin
                    count_reg <= count_reg + 1'b1;
                    tail_reg  <= addr_inc(tail_reg);
                    state_reg <= S_DONE;
                end
                S_TICK: begin
                    if (head_due) begin
                        present_reg <= (override_reg != '0) ? override_reg
                                                            : rd_data_reg.state;
                        head_reg    <= addr_inc(head_reg);
                        count_reg   <= count_reg - 1'b1;
                        fired_reg   <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // hand the result over once the output register frees
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        out_state_reg   <= present_reg;
                        out_fired_reg   <= fired_reg;
                        out_count_reg   <= count_ext[COUNT_OUT_W-1:0];
                        out_dropped_reg <= dropped_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_current_state = out_state_reg;
    assign m_fired         = out_fired_reg;
    assign m_pending_count = out_count_reg;
    assign m_dropped       = out_dropped_reg;

    // The fill never passes the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    // A result never reports both a pop and a drop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_fired && m_dropped))
        else $error("fired and dropped together");

    // A drop happens only on a full queue and leaves it full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && dropped_reg |-> count_reg == FULL_COUNT)
        else $error("drop with room in the queue");

    // A pop removes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) && head_due |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove one entry");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the timed state change queue core.
`timescale 1ns / 1ps

module tb;
    import tscq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    // Receiver hold-off long enough to back the block up into its input channel.
    localparam int LONG_HOLD   = 400;
    // Worst case per item is roughly the slowest sorted insert, plus the longest
    // gap on either side; take it several times over for the whole run.
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

    // Register addresses on the configuration port, four bytes per register.
    localparam logic [2:0] INIT_STATE_ADDR = 3'(4 * int'(REG_INITIAL_STATE));
    localparam logic [2:0] UNMAPPED_ADDR   = 3'(4 * (int'(REG_INITIAL_STATE) + 1));

    typedef struct packed {
        logic               cmd;
        logic [TIME_W-1:0]  now;
        logic [STATE_W-1:0] next;
        logic [TIME_W-1:0]  delay;
        logic [STATE_W-1:0] ovr;
    } timer_item_t;

    typedef struct packed {
        logic [STATE_W-1:0]     state;
        logic                   fired;
        logic [COUNT_OUT_W-1:0] count;
        logic                   dropped;
    } outcome_t;

    // One directed row: an item, how many times to send it (repeats walk the
    // delay down and the target up), and an optional hand-typed outcome.
    typedef struct packed {
        logic               cmd;
        logic [TIME_W-1:0]  now;
        logic [STATE_W-1:0] next;
        logic [TIME_W-1:0]  delay;
        logic [STATE_W-1:0] ovr;
        logic [4:0]         reps;
        logic               typed;
        outcome_t           want;
    } stim_row_t;

    localparam outcome_t NO_TYPED = '0;

    localparam int NUM_ROWS = 17;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // tick on the empty queue after reset, lowest and highest time
        '{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1, '{16'h0000, 1'b0, 5'd0, 1'b0}},
        '{CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b1,
          '{16'h0000, 1'b0, 5'd0, 1'b0}},
        // due at zero, then a due time that wraps past 2^32
        '{CMD_SCHEDULE, 32'h0, 16'hFFFF, 32'h0, 16'h0, 5'd1, 1'b1,
          '{16'h0000, 1'b0, 5'd1, 1'b0}},
        '{CMD_SCHEDULE, 32'hFFFF_FFFF, 16'h0001, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b1,
          '{16'h0000, 1'b0, 5'd2, 1'b0}},
        // two entries with the same due time: the later one must stay behind
        '{CMD_SCHEDULE, 32'd10, 16'h1234, 32'd5, 16'h0, 5'd1, 1'b1,
          '{16'h0000, 1'b0, 5'd3, 1'b0}},
        '{CMD_SCHEDULE, 32'd15, 16'h5678, 32'd0, 16'h0, 5'd1, 1'b1,
          '{16'h0000, 1'b0, 5'd4, 1'b0}},
        '{CMD_TICK, 32'd0, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1, '{16'hFFFF, 1'b1, 5'd3, 1'b0}},
        // head not yet due
        '{CMD_TICK, 32'd14, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1, '{16'hFFFF, 1'b0, 5'd3, 1'b0}},
        '{CMD_TICK, 32'd15, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1, '{16'h1234, 1'b1, 5'd2, 1'b0}},
        // nonzero override replaces the entry's state
        '{CMD_TICK, 32'd15, 16'h0, 32'h0, 16'hFFFF, 5'd1, 1'b1,
          '{16'hFFFF, 1'b1, 5'd1, 1'b0}},
        // wrapped due time is compared plainly, no wraparound correction
        '{CMD_TICK, 32'hFFFF_FFFD, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1,
          '{16'hFFFF, 1'b0, 5'd1, 1'b0}},
        '{CMD_TICK, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1,
          '{16'h0001, 1'b1, 5'd0, 1'b0}},
        // fill with falling due times so every insert walks the whole queue
        '{CMD_SCHEDULE, 32'd100, 16'hA5A0, 32'd1000, 16'h0, 5'd16, 1'b0, NO_TYPED},
        // full queue drops, even an entry that would sort to the head
        '{CMD_SCHEDULE, 32'h0, 16'h7777, 32'h0, 16'h0, 5'd1, 1'b1,
          '{16'h0001, 1'b0, 5'd16, 1'b1}},
        '{CMD_TICK, 32'h0, 16'h0, 32'h0, 16'h0, 5'd1, 1'b1, '{16'h0001, 1'b0, 5'd16, 1'b0}},
        // drain everything, then an override with nothing due
        '{CMD_TICK, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'h0, 5'd16, 1'b0, NO_TYPED},
        '{CMD_TICK, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'h8001, 5'd1, 1'b0, NO_TYPED}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_command = CMD_SCHEDULE;
    logic [TIME_W-1:0]      s_now_ms = '0;
    logic [STATE_W-1:0]     s_next_state = '0;
    logic [TIME_W-1:0]      s_delay_ms = '0;
    logic [STATE_W-1:0]     s_override_state = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATE_W-1:0]     m_current_state;
    logic                   m_fired;
    logic [COUNT_OUT_W-1:0] m_pending_count;
    logic                   m_dropped;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Hand-typed outcome travels with the item it belongs to.
    logic                   use_typed = 1'b0;
    outcome_t               typed_outcome = '0;

    // Shadow copy of the block's queue, current state and register.
    logic [TIME_W-1:0]      shadow_due    [QUEUE_DEPTH];
    logic [STATE_W-1:0]     shadow_target [QUEUE_DEPTH];
    int                     shadow_count = 0;
    logic [STATE_W-1:0]     shadow_present = '0;
    logic [STATE_W-1:0]     shadow_init = '0;

    outcome_t               pending_results [$];
    int                     mismatch_count = 0;
    int                     items_sent = 0;
    int                     fires_seen = 0;
    int                     drops_seen = 0;
    int                     cycle_count = 0;
    bit                     idling_on = 1'b1;
    int                     holdoff_requests = 0;
    int                     holdoff_served = 0;
    int                     stall_left = 0;
    logic [TIME_W-1:0]      timeline_ms = '0;

    timed_state_change_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Sorted insert on schedule, pop of a due head on tick; returns the result
    // the block must give for this item and updates the shadow state.
    function automatic outcome_t apply_timer_item(input timer_item_t it);
        outcome_t          res;
        logic [TIME_W-1:0] due;
        int                pos;
        res = '0;
        if (it.cmd == CMD_SCHEDULE) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                due = it.now + it.delay;
                pos = shadow_count;
                // equal due times stop the walk, so the new entry lands behind them
                while (pos > 0 && shadow_due[pos-1] > due) begin
                    shadow_due[pos]    = shadow_due[pos-1];
                    shadow_target[pos] = shadow_target[pos-1];
                    pos--;
                end
                shadow_due[pos]    = due;
                shadow_target[pos] = it.next;
                shadow_count++;
            end
        end else if (shadow_count != 0 && shadow_due[0] <= it.now) begin
            shadow_present = (it.ovr != '0) ? it.ovr : shadow_target[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_due[i-1]    = shadow_due[i];
                shadow_target[i-1] = shadow_target[i];
            end
            shadow_count--;
            res.fired = 1'b1;
        end
        res.state = shadow_present;
        res.count = COUNT_OUT_W'(shadow_count);
        return res;
    endfunction

    // Check results first, then predict, all in one process so a result and an
    // accepted item on the same edge are handled in a fixed order.
    always @(posedge aclk) begin : scoreboard
        outcome_t    want;
        timer_item_t it;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result with nothing pending", '0, 32'(m_current_state));
                end else begin
                    want = pending_results.pop_front();
                    if (m_current_state !== want.state)
                        note_mismatch("current_state", 32'(want.state), 32'(m_current_state));
                    if (m_fired !== want.fired)
                        note_mismatch("fired", 32'(want.fired), 32'(m_fired));
                    if (m_pending_count !== want.count)
                        note_mismatch("pending_count", 32'(want.count), 32'(m_pending_count));
                    if (m_dropped !== want.dropped)
                        note_mismatch("dropped", 32'(want.dropped), 32'(m_dropped));
                    fires_seen += int'(want.fired);
                    drops_seen += int'(want.dropped);
                end
            end
            if (s_valid && s_ready) begin
                it = '{s_command, s_now_ms, s_next_state, s_delay_ms, s_override_state};
                want = apply_timer_item(it);
                // a typed row still advances the shadow state, but is checked
                // against the value written in the table
                pending_results.push_back(use_typed ? typed_outcome : want);
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when
    // idling is switched off.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served <= holdoff_requests;
            stall_left <= LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item and hold it until accepted; optionally idle first.
    task automatic offer_item(input timer_item_t it, input logic typed,
                              input outcome_t want);
        if (idling_on && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= it.cmd;
        s_now_ms         <= it.now;
        s_next_state     <= it.next;
        s_delay_ms       <= it.delay;
        s_override_state <= it.ovr;
        use_typed        <= typed;
        typed_outcome    <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // writing initial_state also loads the current state; other addresses do nothing
        if (addr == INIT_STATE_ADDR) begin
            shadow_init    = data[STATE_W-1:0];
            shadow_present = data[STATE_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic read_back_initial_state();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= INIT_STATE_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[STATE_W-1:0] !== shadow_init)
            note_mismatch("initial_state readback", 32'(shadow_init), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly a coherent timeline (time moves forward, short delays, ticks at
    // the current time) so entries actually come due; the rest is noise with
    // full-range fields. The schedule/tick mix drifts so the queue both fills
    // up to dropping and drains to empty.
    task automatic run_random_items(input int count);
        timer_item_t it;
        int          schedule_pct;
        schedule_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                schedule_pct = $urandom_range(15, 85);
            it.next = STATE_W'($urandom);
            it.ovr  = STATE_W'($urandom);
            if ($urandom_range(0, 99) < 8) begin
                it.cmd   = logic'($urandom_range(0, 1));
                it.now   = $urandom;
                it.delay = $urandom;
            end else begin
                timeline_ms += $urandom_range(0, 3);
                it.now = timeline_ms;
                if ($urandom_range(0, 99) < schedule_pct) begin
                    it.cmd   = CMD_SCHEDULE;
                    it.delay = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
                end else begin
                    it.cmd   = CMD_TICK;
                    it.delay = $urandom;
                    // zero override half the time so the entry's own state shows
                    if ($urandom_range(0, 1) == 0)
                        it.ovr = '0;
                end
            end
            offer_item(it, 1'b0, NO_TYPED);
        end
    endtask

    initial begin : stimulus
        stim_row_t   row;
        timer_item_t it;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_back_initial_state();

        // Directed part, with the register at its reset value.
        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            for (int k = 0; k < int'(row.reps); k++) begin
                it = '{row.cmd, row.now, row.next + STATE_W'(k), row.delay - TIME_W'(k),
                       row.ovr};
                offer_item(it, row.typed, row.want);
            end
        end
        wait_until_drained();

        // Highest initial state; unmapped address must leave it alone. Ask the
        // receiver for one long hold-off while items keep coming.
        write_register(INIT_STATE_ADDR, 32'h0000_FFFF);
        write_register(UNMAPPED_ADDR, $urandom);
        read_back_initial_state();
        holdoff_requests++;
        run_random_items(200);
        wait_until_drained();

        // Lowest initial state, written with whatever the queue still holds.
        write_register(INIT_STATE_ADDR, 32'h0);
        read_back_initial_state();
        run_random_items(200);
        wait_until_drained();

        // Random initial state, then a last stretch at full rate on both sides.
        write_register(INIT_STATE_ADDR, $urandom);
        read_back_initial_state();
        idling_on = 1'b0;
        run_random_items(180);
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items through the queue: %0d entries fired, %0d schedules dropped,",
                 items_sent, fires_seen, drops_seen);
        $display("four initial_state settings and one long receiver hold-off; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/tscq_pkg.sv
sv/timed_state_change_queue_core.sv
bench/tb.sv
